@@ hdl/length_prefixed_packet_deframer_macros.svh @@
// assertion macros for the deframer checker
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LPPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer output check failed");

// next-cycle implication, sampled on clk, off during reset
`define LPPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer output hold check failed");

`endif

@@ hdl/lppd_pkg.sv @@
`timescale 1ns / 1ps
package lppd_pkg;

    localparam logic [1:0] CMD_BYTE   = 2'd0;
    localparam logic [1:0] CMD_RDERR  = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_RETURN = 2'd3;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_BYTE    = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_IOERR   = 2'd3;

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_HUNT  = 3'd1;
    localparam logic [2:0] MODE_RECV  = 3'd2;
    localparam logic [2:0] MODE_DONE  = 3'd3;
    localparam logic [2:0] MODE_ERROR = 3'd4;

    localparam logic CFG_ENABLE  = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam int          TIMEOUT_W       = 16;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd5000;
    localparam logic [11:0] PKT_OVERHEAD    = 12'd4;
    localparam int          QUEUE_DEPTH     = 2;
    localparam int          QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int          QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_HUNT  = 5'b00010,
        ST_RECV  = 5'b00100,
        ST_DONE  = 5'b01000,
        ST_ERROR = 5'b10000
    } state_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic       hdr_ok;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic                   enable;
        logic [TIMEOUT_W-1:0]   timeout_ticks;
    } cfg_t;

    function automatic logic [2:0] mode_code(input state_t st);
        logic [2:0] code;
        case (st)
            ST_IDLE:  code = MODE_IDLE;
            ST_HUNT:  code = MODE_HUNT;
            ST_RECV:  code = MODE_RECV;
            ST_DONE:  code = MODE_DONE;
            ST_ERROR: code = MODE_ERROR;
            default:  code = MODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

@@ hdl/lppd_front.sv @@
`timescale 1ns / 1ps
module lppd_front
    import lppd_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] rx_byte,
    input  q_status_t  q_status,
    output push_t      push
);

    // header candidate: bits 6:3 clear
    assign push.item.hdr_ok  = (rx_byte[6:3] == 4'h0);
    assign push.item.cmd     = cmd;
    assign push.item.rx_byte = rx_byte;
    assign push.valid        = in_valid && !q_status.full;
    assign in_stall          = q_status.full;

endmodule

@@ hdl/lppd_queue.sv @@
`timescale 1ns / 1ps
module lppd_queue
    import lppd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  push_t     push,
    input  logic      pop,
    output q_status_t q_status,
    output item_t     head
);

    item_t                  slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign q_status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push.valid && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

@@ hdl/lppd_back.sv @@
`timescale 1ns / 1ps
module lppd_back
    import lppd_pkg::*;
#(
    parameter int TIMER_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  q_status_t   q_status,
    input  item_t       head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  packet_byte,
    output logic [11:0] byte_index,
    output logic        first,
    output logic        last,
    output logic [2:0]  parser_mode
);

    localparam int CMP_W = (TIMER_WIDTH > TIMEOUT_W) ? TIMER_WIDTH : TIMEOUT_W;

    state_t                 state_reg, state_next, state_eff;
    logic [11:0]            count_reg, count_next;
    logic [10:0]            plen_reg, plen_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next, timer_inc;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             kind_reg, kind_next;
    logic [7:0]             byte_reg, byte_next;
    logic [11:0]            index_reg, index_next;
    logic                   first_reg, first_next;
    logic                   last_reg, last_next;
    logic [2:0]             mode_reg;
    logic [10:0]            plen_upd;
    logic [11:0]            count_inc;
    logic [11:0]            pkt_end;

    assign pop = !q_status.empty && (!out_valid_reg || !out_stall);

    assign timer_inc = (&timer_reg) ? timer_reg : timer_reg + 1'b1;
    assign plen_upd  = (count_reg == 12'd1) ? {plen_reg[10:8], head.rx_byte} : plen_reg;
    assign count_inc = count_reg + 12'd1;
    assign pkt_end   = {1'b0, plen_upd} + PKT_OVERHEAD;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        plen_next  = plen_reg;
        timer_next = timer_reg;
        kind_next  = KIND_NONE;
        byte_next  = '0;
        index_next = '0;
        first_next = 1'b0;
        last_next  = 1'b0;
        state_eff  = state_reg;
        if ((state_reg == ST_IDLE && cfg.enable) || state_reg == ST_DONE)
        begin
            state_eff = ST_HUNT;
        end
        if (head.cmd == CMD_RETURN)
        begin
            state_next = ST_IDLE;
            count_next = '0;
            plen_next  = '0;
            timer_next = '0;
        end
        else
        begin
            state_next = state_eff;
            case (state_eff)
                ST_HUNT:
                begin
                    if (head.cmd == CMD_RDERR)
                    begin
                        state_next = ST_ERROR;
                        kind_next  = KIND_IOERR;
                    end
                    else if (head.cmd == CMD_BYTE && head.hdr_ok)
                    begin
                        plen_next  = {head.rx_byte[2:0], 8'h00};
                        count_next = 12'd1;
                        timer_next = '0;
                        state_next = ST_RECV;
                        kind_next  = KIND_BYTE;
                        byte_next  = head.rx_byte;
                        first_next = 1'b1;
                    end
                end
                ST_RECV:
                begin
                    if (head.cmd == CMD_RDERR)
                    begin
                        state_next = ST_ERROR;
                        kind_next  = KIND_IOERR;
                    end
                    else if (head.cmd == CMD_TICK)
                    begin
                        timer_next = timer_inc;
                        if (CMP_W'(timer_inc) >= CMP_W'(cfg.timeout_ticks))
                        begin
                            kind_next  = KIND_TIMEOUT;
                            state_next = ST_HUNT;
                            count_next = '0;
                            timer_next = '0;
                        end
                    end
                    else
                    begin
                        kind_next  = KIND_BYTE;
                        byte_next  = head.rx_byte;
                        index_next = count_reg;
                        plen_next  = plen_upd;
                        count_next = count_inc;
                        timer_next = '0;
                        if (count_inc >= 12'd2 && count_inc >= pkt_end)
                        begin
                            last_next  = 1'b1;
                            state_next = ST_DONE;
                            count_next = '0;
                        end
                    end
                end
                default:
                begin
                    state_next = state_eff;
                end
            endcase
        end
    end

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            plen_reg      <= '0;
            timer_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                state_reg <= state_next;
                count_reg <= count_next;
                plen_reg  <= plen_next;
                timer_reg <= timer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= kind_next;
            byte_reg  <= byte_next;
            index_reg <= index_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            mode_reg  <= mode_code(state_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign packet_byte = byte_reg;
    assign byte_index  = index_reg;
    assign first       = first_reg;
    assign last        = last_reg;
    assign parser_mode = mode_reg;

endmodule

@@ hdl/length_prefixed_packet_deframer.sv @@
// length-prefixed packet deframer
// input channel: in_valid/in_stall with cmd (byte, read error, tick, return to idle)
//   and rx_byte; one word per cycle is taken while the two-entry queue has room
// output channel: out_valid/out_stall with kind, packet_byte, byte_index, first,
//   last and parser_mode; exactly one result word per input word, in order
// config channel: cfg_valid/cfg_ready (always ready), cfg_index 0 enable,
//   cfg_index 1 timeout_ticks in cfg_data
// path: an accepted word is written into a queue entry, then the back end pops it
//   into the output registers, where the receiver can take it
// throughput: one word per cycle while the receiver does not stall the output
// reset: parser idle, counters and timer cleared, queue and output empty,
//   enable 0, timeout_ticks 5000
// receiver stall: the output word holds, the back end stops popping, the queue
//   fills behind it and in_stall rises once both queue entries are taken
`timescale 1ns / 1ps
module length_prefixed_packet_deframer
    import lppd_pkg::*;
#(
    parameter int TIMER_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  packet_byte,
    output logic [11:0] byte_index,
    output logic        first,
    output logic        last,
    output logic [2:0]  parser_mode,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t      cfg_reg;
    q_status_t q_status;
    push_t     push;
    item_t     head;
    logic      pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= 1'b0;
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ENABLE:  cfg_reg.enable        <= cfg_data[0];
                CFG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_data;
                default:     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    lppd_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .rx_byte  (rx_byte),
        .q_status (q_status),
        .push     (push)
    );

    lppd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (pop),
        .q_status (q_status),
        .head     (head)
    );

    lppd_back #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_status    (q_status),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .packet_byte (packet_byte),
        .byte_index  (byte_index),
        .first       (first),
        .last        (last),
        .parser_mode (parser_mode)
    );

endmodule

@@ hdl/lppd_checker.sv @@
`timescale 1ns / 1ps
`include "length_prefixed_packet_deframer_macros.svh"
module lppd_checker
    import lppd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [7:0]  packet_byte,
    input logic [11:0] byte_index,
    input logic        first,
    input logic        last,
    input logic [2:0]  parser_mode
);

    // non-byte results carry a zero payload
    `LPPD_ASSERT_NOW(a_zero_payload, out_valid && kind != KIND_BYTE,
        packet_byte == 8'h00 && byte_index == 12'd0 && !first && !last)

    // a header byte sits at index zero and opens reception
    `LPPD_ASSERT_NOW(a_first_recv, out_valid && first,
        kind == KIND_BYTE && byte_index == 12'd0 && parser_mode == MODE_RECV)

    // the closing byte leaves the parser done
    `LPPD_ASSERT_NOW(a_last_done, out_valid && last,
        kind == KIND_BYTE && !first && parser_mode == MODE_DONE)

    // an io error always lands in the error mode
    `LPPD_ASSERT_NOW(a_ioerr_mode, out_valid && kind == KIND_IOERR, parser_mode == MODE_ERROR)

    // a stalled result word holds
    `LPPD_ASSERT_NEXT(a_hold, out_valid && out_stall,
        out_valid && $stable(kind) && $stable(byte_index) && $stable(parser_mode))

endmodule

bind length_prefixed_packet_deframer lppd_checker u_lppd_checker (.*);

@@ sim/length_prefixed_packet_deframer_test.sv @@
`timescale 1ns / 1ps
module length_prefixed_packet_deframer_test;
    import lppd_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int END_HOLDOFF    = 8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [11:0] index;
        logic        is_first;
        logic        is_last;
        logic [2:0]  mode;
    } deframe_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = CMD_BYTE;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  packet_byte;
    logic [11:0] byte_index;
    logic        first;
    logic        last;
    logic [2:0]  parser_mode;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_ENABLE;
    logic [15:0] cfg_data = 16'd0;

    // deframer state as predicted
    logic        pred_enable = 1'b0;
    logic [15:0] pred_timeout = TIMEOUT_RESET;
    logic [2:0]  pred_mode = MODE_IDLE;
    logic [11:0] pred_count = 12'd0;
    logic [10:0] pred_length = 11'd0;
    logic [15:0] pred_timer = 16'd0;

    deframe_word_t expected_words[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    int words_sent = 0;
    int results_checked = 0;
    int packets_done = 0;
    int timeouts_seen = 0;
    int ioerrs_seen = 0;
    int idle_cycles = 0;

    length_prefixed_packet_deframer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .packet_byte (packet_byte),
        .byte_index  (byte_index),
        .first       (first),
        .last        (last),
        .parser_mode (parser_mode),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic deframe_word_t deframe_step(input logic [1:0] c, input logic [7:0] b);
        deframe_word_t r;
        r = '0;
        r.kind = KIND_NONE;
        if (c == CMD_RETURN)
        begin
            pred_mode = MODE_IDLE;
            pred_count = 12'd0;
            pred_length = 11'd0;
            pred_timer = 16'd0;
        end
        else
        begin
            if (pred_mode == MODE_IDLE && pred_enable)
                pred_mode = MODE_HUNT;
            if (pred_mode == MODE_DONE)
                pred_mode = MODE_HUNT;
            if (pred_mode == MODE_HUNT)
            begin
                if (c == CMD_RDERR)
                begin
                    pred_mode = MODE_ERROR;
                    r.kind = KIND_IOERR;
                end
                else if (c == CMD_BYTE && b[6:3] == 4'd0)
                begin
                    pred_length = {b[2:0], 8'd0};
                    pred_count = 12'd1;
                    pred_timer = 16'd0;
                    pred_mode = MODE_RECV;
                    r.kind = KIND_BYTE;
                    r.data = b;
                    r.index = 12'd0;
                    r.is_first = 1'b1;
                end
            end
            else if (pred_mode == MODE_RECV)
            begin
                if (c == CMD_RDERR)
                begin
                    pred_mode = MODE_ERROR;
                    r.kind = KIND_IOERR;
                end
                else if (c == CMD_TICK)
                begin
                    if (pred_timer != 16'hFFFF)
                        pred_timer = pred_timer + 16'd1;
                    if (pred_timer >= pred_timeout)
                    begin
                        r.kind = KIND_TIMEOUT;
                        pred_mode = MODE_HUNT;
                        pred_count = 12'd0;
                        pred_timer = 16'd0;
                    end
                end
                else
                begin
                    r.kind = KIND_BYTE;
                    r.data = b;
                    r.index = pred_count;
                    if (pred_count == 12'd1)
                        pred_length[7:0] = b;
                    pred_count = pred_count + 12'd1;
                    pred_timer = 16'd0;
                    if (pred_count >= 12'd2 && pred_count >= {1'b0, pred_length} + PKT_OVERHEAD)
                    begin
                        r.is_last = 1'b1;
                        pred_mode = MODE_DONE;
                        pred_count = 12'd0;
                    end
                end
            end
        end
        r.mode = pred_mode;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [11:0] got,
                                   input logic [11:0] want);
        error_count++;
        $display("%0t mismatch on %s: got %0h, want %0h", $time, field, got, want);
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin : check_output
        deframe_word_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word, kind", {10'd0, kind}, 12'd0);
            else
            begin
                want = expected_words.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", {10'd0, kind}, {10'd0, want.kind});
                if (packet_byte !== want.data)
                    report_mismatch("packet_byte", {4'd0, packet_byte}, {4'd0, want.data});
                if (byte_index !== want.index)
                    report_mismatch("byte_index", byte_index, want.index);
                if (first !== want.is_first)
                    report_mismatch("first", {11'd0, first}, {11'd0, want.is_first});
                if (last !== want.is_last)
                    report_mismatch("last", {11'd0, last}, {11'd0, want.is_last});
                if (parser_mode !== want.mode)
                    report_mismatch("parser_mode", {9'd0, parser_mode}, {9'd0, want.mode});
                results_checked++;
                if (want.is_last)
                    packets_done++;
                if (want.kind == KIND_TIMEOUT)
                    timeouts_seen++;
                if (want.kind == KIND_IOERR)
                    ioerrs_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
            || (cfg_valid && cfg_ready === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_word(input logic [1:0] c, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        expected_words.push_back(deframe_step(c, b));
        words_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (END_HOLDOFF) @(posedge clk);
    endtask

    // both registers, back to back on the config channel
    task automatic configure(input logic en, input logic [15:0] tmo);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ENABLE;
        cfg_data <= {15'd0, en};
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        pred_enable = en;
        cfg_index <= CFG_TIMEOUT;
        cfg_data <= tmo;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        pred_timeout = tmo;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_word(CMD_TICK, rand_byte());
    endtask

    // header, length byte, then payload_count further bytes with ticks under the timeout
    task automatic send_packet(input logic [10:0] len, input int payload_count,
                               input int tick_pct);
        logic [7:0] hdr;
        hdr = rand_byte();
        hdr[6:3] = 4'b0000;
        hdr[2:0] = len[10:8];
        send_word(CMD_BYTE, hdr);
        send_word(CMD_BYTE, len[7:0]);
        for (int i = 0; i < payload_count; i++)
        begin
            if (pred_timeout > 16'd1 && $urandom_range(99) < tick_pct)
                send_ticks($urandom_range((pred_timeout > 16'd4) ? 3 : int'(pred_timeout) - 1));
            send_word(CMD_BYTE, rand_byte());
        end
    endtask

    function automatic logic [10:0] packet_length();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return 11'($urandom_range(6));
        else if (r < 99)
            return 11'($urandom_range(7, 40));
        else
            return 11'($urandom_range(256, 270));
    endfunction

    task automatic test_disabled_parser();
        configure(1'b0, TIMEOUT_RESET);
        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_TICK, 8'hFF);
        send_word(CMD_RDERR, 8'h5A);
        send_word(CMD_RETURN, 8'hA5);
        wait_drained();
    endtask

    task automatic test_framing_extremes();
        configure(1'b1, 16'hFFFF);
        // shortest packet, then one with bit 7 set in the header
        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_BYTE, 8'hFF);
        send_word(CMD_BYTE, 8'h80);
        send_word(CMD_BYTE, 8'h80);
        send_word(CMD_BYTE, 8'h01);
        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_BYTE, 8'hFF);
        send_word(CMD_BYTE, 8'h7F);
        // start bytes that must be dropped
        send_word(CMD_BYTE, 8'h08);
        send_word(CMD_BYTE, 8'h78);
        send_word(CMD_BYTE, 8'h40);
        send_word(CMD_BYTE, 8'hFF);
        // largest length field, abandoned
        send_word(CMD_BYTE, 8'h87);
        send_word(CMD_BYTE, 8'hFF);
        send_word(CMD_RETURN, 8'h12);
        wait_drained();
    endtask

    task automatic test_error_mode();
        send_word(CMD_RDERR, 8'h00);
        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_TICK, 8'h00);
        send_word(CMD_RDERR, 8'h00);
        send_word(CMD_RETURN, 8'h00);
        send_word(CMD_BYTE, 8'h01);
        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_RDERR, 8'hFF);
        send_word(CMD_RETURN, 8'hFF);
        wait_drained();
    endtask

    task automatic test_tick_handling();
        configure(1'b1, 16'd0);
        send_word(CMD_TICK, 8'h00);
        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_TICK, 8'h00);
        wait_drained();
        configure(1'b1, 16'd2);
        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_BYTE, 8'h00);
        send_ticks(2);
        send_packet(11'd0, 2, 0);
        send_word(CMD_TICK, 8'h00);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input logic [15:0] tmo, input int count);
        int start;
        int sel;
        wait_drained();
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        configure(1'b1, tmo);
        start = words_sent;
        while (words_sent - start < count)
        begin
            sel = $urandom_range(99);
            if (pred_mode == MODE_ERROR || pred_mode == MODE_RECV)
                send_word(CMD_RETURN, rand_byte());
            if (sel < 60)
            begin : full_packet
                logic [10:0] len;
                len = packet_length();
                send_packet(len, int'(len) + 2, 30);
            end
            else if (sel < 68)
                repeat ($urandom_range(1, 4)) send_word(CMD_BYTE, rand_byte());
            else if (sel < 78)
            begin
                // packet starved of bytes until it times out, or ended by a return when the timeout is above 16
                send_packet(11'($urandom_range(8, 2047)), $urandom_range(4), 30);
                if (pred_timeout <= 16'd16)
                    send_ticks((pred_timeout == 16'd0) ? 1 : int'(pred_timeout));
                else
                    send_word(CMD_RETURN, rand_byte());
            end
            else if (sel < 85)
            begin
                send_packet(11'($urandom_range(8, 2047)), $urandom_range(4), 30);
                send_word(CMD_RETURN, rand_byte());
            end
            else if (sel < 90)
            begin
                send_word(CMD_RDERR, rand_byte());
                repeat ($urandom_range(1, 3)) send_word(2'($urandom_range(2)), rand_byte());
                send_word(CMD_RETURN, rand_byte());
            end
            else
                repeat ($urandom_range(1, 5)) send_word(2'($urandom_range(3)), rand_byte());
            if ($urandom_range(99) < 4)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        send_idle_pct = 35;
        recv_idle_pct = 87;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_disabled_parser();
        test_framing_extremes();
        test_error_mode();
        test_tick_handling();
        test_random_traffic(35, 87, 16'd4, 300);
        test_random_traffic(87, 35, 16'd1, 300);
        test_random_traffic(0, 0, 16'hFFFF, 300);
        wait_drained();
        $display("run covered %0d input words and %0d checked results over three idling mixes",
                 words_sent, results_checked);
        $display("%0d packets completed, %0d timeout aborts, %0d io errors",
                 packets_done, timeouts_seen, ioerrs_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/lppd_pkg.sv
hdl/lppd_front.sv
hdl/lppd_queue.sv
hdl/lppd_back.sv
hdl/length_prefixed_packet_deframer.sv
hdl/lppd_checker.sv
sim/length_prefixed_packet_deframer_test.sv
